// File: src/bda_pkg.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII package
// Shared constants, FSM state type and the cell control bundle.
// ----------------------------------------------------------------------------
package bda_pkg;

	localparam int VALUE_WIDTH_DEF = 16;
	localparam int NUM_DIGITS      = 5;
	localparam int MAX_SHOWN       = 99999;
	localparam int MAX_SHOWN_W     = 17;
	localparam int DIGIT_W         = 4;
	localparam int CHAR_W          = 6;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	// Control shared by every digit cell
	typedef struct packed {
		logic clear;       // zero the digit
		logic shift_bit;   // add-3 correction, then shift one binary bit in
		logic shift_digit; // move the digit one cell up
	} cell_ctl_t;

endpackage

// File: src/bda_cell.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII digit cell
// One BCD digit of the shift-and-add-3 chain; passes its top bit or its
// whole digit to the next more significant cell.
// ----------------------------------------------------------------------------
module bda_cell (
	input  logic                      clk,
	input  bda_pkg::cell_ctl_t        ctl,
	input  logic                      bit_in,
	input  logic [bda_pkg::DIGIT_W-1:0] digit_in,
	output logic                      bit_out,
	output logic [bda_pkg::DIGIT_W-1:0] digit
);
	import bda_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	// Correct digits of five or more before doubling
	always_comb begin
		adj = (digit_q >= DIGIT_W'(5)) ? digit_q + DIGIT_W'(3) : digit_q;
	end

	assign bit_out = adj[DIGIT_W-1];
	assign digit   = digit_q;

	// Clear, shift a bit in, or take the neighbor's digit
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.shift_bit) begin
			digit_q <= {adj[DIGIT_W-2:0], bit_in};
		end else if (ctl.shift_digit) begin
			digit_q <= digit_in;
		end
	end

endmodule

// File: src/binary_to_decimal_ascii.sv
// A request is converted by a bit-serial double-dabble pass through the digit-cell
// chain; its digits then leave from the top cell of the chain, most significant first.
// No new request is accepted until the last digit has been loaded into the output register;
// digits leave one per cycle while the output is not stalled by m_tready.
// Reset: arst_n asynchronously returns the controller to idle and drops m_tvalid.
// ----------------------------------------------------------------------------
// Binary to decimal ASCII converter
// Converts an unsigned value, clamped to 99999, to decimal ASCII digits with leading zeros
// suppressed, using a chain of BCD cells driven by a small controller.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
	parameter int VALUE_WIDTH = bda_pkg::VALUE_WIDTH_DEF,
	localparam int IN_TDW = ((VALUE_WIDTH + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_TDW-1:0] s_tdata,   // [VALUE_WIDTH-1:0] value
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // [5:0] digit_char
	output logic              m_tlast    // last_digit
);
	import bda_pkg::*;

	localparam int CMP_W = (VALUE_WIDTH > MAX_SHOWN_W) ? VALUE_WIDTH : MAX_SHOWN_W;
	localparam int CNT_W = $clog2(VALUE_WIDTH);
	localparam int REM_W = $clog2(NUM_DIGITS + 1);

	state_t              state_q, state_d;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [REM_W-1:0]    rem_q;
	logic                started_q;
	logic                m_tvalid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;

	cell_ctl_t           ctl;
	logic                out_free;
	logic                load_out;
	logic                rem_dec;
	logic [CMP_W-1:0]    value_ext;
	logic [CMP_W-1:0]    sat_ext;
	logic [DIGIT_W-1:0]  top_digit;

	logic [DIGIT_W-1:0]  digit_w [NUM_DIGITS];
	logic                carry_w [NUM_DIGITS];

	// Clamp to the five-digit range
	always_comb begin
		value_ext = CMP_W'(s_tdata[VALUE_WIDTH-1:0]);
		sat_ext   = (value_ext > CMP_W'(MAX_SHOWN)) ? CMP_W'(MAX_SHOWN) : value_ext;
	end

	// Digit cell chain, least significant cell first
	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		bda_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.bit_in   ((i == 0) ? val_q[VALUE_WIDTH-1] : carry_w[(i == 0) ? 0 : i - 1]),
			.digit_in ((i == 0) ? '0 : digit_w[(i == 0) ? 0 : i - 1]),
			.bit_out  (carry_w[i]),
			.digit    (digit_w[i])
		);
	end

	assign top_digit = digit_w[NUM_DIGITS-1];
	assign out_free  = !m_tvalid_q || m_tready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_CONV;
			ST_CONV: if (cnt_q == '0) state_d = ST_EMIT;
			ST_EMIT: if (out_free && rem_q == REM_W'(1)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Controller outputs
	always_comb begin
		s_tready = 1'b0;
		ctl      = '0;
		load_out = 1'b0;
		rem_dec  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				ctl.clear = s_tvalid;
			end
			ST_CONV: begin
				ctl.shift_bit = 1'b1;
			end
			ST_EMIT: begin
				if (out_free) begin
					ctl.shift_digit = 1'b1;
					rem_dec         = 1'b1;
					// drop leading zeros, always keep the units digit
					load_out = started_q || (top_digit != '0) || (rem_q == REM_W'(1));
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			rem_q      <= '0;
			started_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && s_tvalid) begin
				cnt_q     <= CNT_W'(VALUE_WIDTH - 1);
				rem_q     <= REM_W'(NUM_DIGITS);
				started_q <= 1'b0;
			end else if (state_q == ST_CONV) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (rem_dec) begin
				rem_q <= rem_q - REM_W'(1);
			end
			if (load_out) begin
				started_q <= 1'b1;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Value shifter and output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			val_q <= sat_ext[VALUE_WIDTH-1:0];
		end else if (state_q == ST_CONV) begin
			val_q <= {val_q[VALUE_WIDTH-2:0], 1'b0};
		end
		if (load_out) begin
			char_q <= ASCII_ZERO | CHAR_W'(top_digit);
			last_q <= (rem_q == REM_W'(1));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, char_q};
	assign m_tlast  = last_q;

`ifndef SYNTH
	a_conv_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV && cnt_q == '0) |=> state_q == ST_EMIT)
		else $error("conversion did not hand over to digit output");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (rem_q != '0 && rem_q <= REM_W'(NUM_DIGITS)))
		else $error("digit count out of range during output");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5:4] == 2'b11 && m_tdata[3:0] <= 4'd9))
		else $error("output character is not a decimal digit");

	a_accept_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> state_q == ST_CONV)
		else $error("accepted request did not start conversion");
`endif

endmodule
